/* rtl/core/rssiq_pkg.sv */
// shared types and constants for the rssi averager with quality bars
// no dependencies; imported by every module of the block except rssiq_ram
`default_nettype none
package rssiq_pkg;

  localparam int WINDOW_LENGTH = 150;
  localparam int SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int NUM_LEVELS = 4;
  localparam int ADDR_W = 4;

  // reciprocal of the window length for the mean, exact for every |sum| the window can reach (at most 19200)
  localparam int RECIP_SHIFT = 22;
  localparam logic [14:0] RECIP = 15'((2 ** RECIP_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH);
  localparam logic [6:0] QUALITY_MAX = 7'd100;

  typedef logic signed [63:0] coef_t;
  localparam coef_t POLY [7] = '{
    64'sd111371345297556,
    64'sd702050051029,
    64'sd89605154045,
    64'sd4377588081,
    64'sd87338926,
    64'sd831429,
    64'sd3022
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_MEAN,
    ST_POLY,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       upd;
    logic       div;
    logic       mean;
    logic       step;
    logic [2:0] coef_idx;
    logic       load;
  } cmd_t;

  typedef logic signed [7:0] level_t;

endpackage
`default_nettype wire

/* rtl/core/rssiq_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module rssiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/rssiq_cfg.sv */
// apb register file holding the four bar thresholds
// depends on rssiq_pkg
`default_nettype none
module rssiq_cfg import rssiq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output level_t                 levels [NUM_LEVELS]
);

  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels[0] <= -8'sd90;
      levels[1] <= -8'sd80;
      levels[2] <= -8'sd70;
      levels[3] <= -8'sd50;
    end else if (psel && penable && pwrite) begin
      levels[idx] <= pwdata[7:0];
    end
  end

  assign prdata = {{24{levels[idx][7]}}, levels[idx]};

endmodule
`default_nettype wire

/* rtl/core/rssiq_ctrl.sv */
// sequencer for one request: window update, mean, six horner steps, output load
// depends on rssiq_pkg
`default_nettype none
module rssiq_ctrl import rssiq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_busy,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic [2:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.coef_idx = step;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: state_next = ST_SUM;
      ST_SUM: begin
        cmd.upd    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.mean   = 1'b1;
        step_next  = 3'd5;
        state_next = ST_POLY;
      end
      ST_POLY: begin
        cmd.step = 1'b1;
        if (step == 3'd0) begin
          state_next = ST_LOAD;
        end else begin
          step_next = step - 3'd1;
        end
      end
      ST_LOAD: begin
        // wait while the previous result is still held
        if (!out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/rssiq_dp.sv */
// datapath: sample ring, running sum, reciprocal mean, horner unit, bars
// depends on rssiq_pkg and rssiq_ram
`default_nettype none
module rssiq_dp import rssiq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cmd_t             cmd,
  input  wire logic [7:0]  rssi_dbm,
  input  level_t           levels [NUM_LEVELS],
  input  wire logic        out_stall,
  output logic             out_busy,
  output logic             out_valid,
  output logic [7:0]       mean_dbm,
  output logic [6:0]       quality_percent,
  output logic [2:0]       bars_lit
);

  logic signed [7:0]  sample;
  logic signed [7:0]  prime_val;
  logic signed [15:0] sum;
  logic [SLOT_W-1:0]  slot;
  logic               primed;
  logic               first_pass;
  logic [7:0]         rdata;
  logic               ram_we;
  logic signed [7:0]  old;
  logic [14:0]        abs_sum;
  logic [29:0]        prod;
  logic               neg;
  logic [7:0]         q;
  logic signed [7:0]  mean;
  logic signed [63:0] h;
  logic signed [71:0] mh;
  logic [6:0]         quality;
  logic [2:0]         bars;

  rssiq_ram #(.WIDTH(8), .DEPTH(WINDOW_LENGTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (sample),
    .raddr (slot),
    .rdata (rdata)
  );

  assign ram_we = cmd.upd && primed;
  // slots not yet rewritten since priming still hold the priming sample
  assign old = first_pass ? prime_val : signed'(rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      slot       <= '0;
      primed     <= 1'b0;
      first_pass <= 1'b0;
    end else if (cmd.upd) begin
      if (!primed) begin
        primed     <= 1'b1;
        first_pass <= 1'b1;
        prime_val  <= sample;
        sum        <= 16'(16'(sample) * 16'(WINDOW_LENGTH));
        slot       <= '0;
      end else begin
        sum <= sum - 16'(old) + 16'(sample);
        if (slot == SLOT_W'(WINDOW_LENGTH - 1)) begin
          slot       <= '0;
          first_pass <= 1'b0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
    end
  end

  assign abs_sum = sum[15] ? 15'(-sum) : sum[14:0];
  assign q = 8'(prod >> RECIP_SHIFT);
  assign mh = h * mean;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= rssi_dbm;
    end
    if (cmd.div) begin
      prod <= 30'(abs_sum) * 30'(RECIP);
      neg  <= sum[15];
    end
    if (cmd.mean) begin
      mean <= neg ? -q : q;
      h    <= POLY[6];
    end
    if (cmd.step) begin
      h <= POLY[cmd.coef_idx] + mh[63:0];
    end
  end

  always_comb begin
    if (h[63]) begin
      quality = '0;
    end else if (h[62:40] > 23'(QUALITY_MAX)) begin
      quality = QUALITY_MAX;
    end else begin
      quality = h[46:40];
    end
    bars = '0;
    if (mean != 8'sd0) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (mean > levels[i]) begin
          bars = bars + 3'd1;
        end
      end
    end
  end

  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean_dbm        <= mean;
      quality_percent <= quality;
      bars_lit        <= bars;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rssi_average_quality_bars.sv */
// top level of the rssi averager: sequencer, datapath and threshold registers
// depends on rssiq_pkg, rssiq_ctrl, rssiq_dp, rssiq_cfg
`default_nettype none
// Each request is taken through these steps from acceptance to a result ready
// to be taken: one ring read, the running sum update, the mean by reciprocal
// multiply in the divide and mean steps, six steps of the shared Horner
// multiplier and the output load. The input is stalled for the whole sequence,
// so a new request is taken only once the sequencer is back in idle; one result
// is held in the output register while the next request is already being worked
// on, and a stalled result holds the next one in the load step. The first sample
// after reset fills the whole window, with no clearing pass.
module rssi_average_quality_bars import rssiq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        rssi_dbm,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             mean_dbm,
  output logic [6:0]             quality_percent,
  output logic [2:0]             bars_lit,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cmd_t   cmd;
  logic   out_busy;
  level_t levels [NUM_LEVELS];

  rssiq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .levels  (levels)
  );

  rssiq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  rssiq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .rssi_dbm        (rssi_dbm),
    .levels          (levels),
    .out_stall       (out_stall),
    .out_busy        (out_busy),
    .out_valid       (out_valid),
    .mean_dbm        (mean_dbm),
    .quality_percent (quality_percent),
    .bars_lit        (bars_lit)
  );

endmodule
`default_nettype wire

/* rtl/core/rssiq_chk.sv */
// port level checks for the rssi averager, bound to the top level
// depends on rssiq_pkg
`default_nettype none
module rssiq_chk import rssiq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [7:0]        mean_dbm,
  input wire logic [6:0]        quality_percent,
  input wire logic [2:0]        bars_lit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_dbm))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_quality_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quality_percent <= QUALITY_MAX)
    else $error("quality above range");

  a_zero_mean_bars: assert property (@(posedge clk) disable iff (rst)
    out_valid && mean_dbm == 8'd0 |-> bars_lit == 3'd0)
    else $error("bars lit with zero mean");

  a_bars_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bars_lit <= 3'(NUM_LEVELS))
    else $error("too many bars");

endmodule

bind rssi_average_quality_bars rssiq_chk u_chk (.*);
`default_nettype wire

/* bench/rssi_average_quality_bars_tb.sv */
// testbench for the rssi averager: random bursts of samples with a predicted window mean,
// polynomial quality percent and bar count; depends on rssiq_pkg and rssi_average_quality_bars
module rssi_average_quality_bars_tb;
  import rssiq_pkg::*;

  localparam int WIN = 150;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [ADDR_W-1:0] ADDR_LEVEL_ONE = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_LEVEL_TWO = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_LEVEL_THREE = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_LEVEL_FOUR = 4'd12;

  typedef struct {
    logic signed [7:0] mean;
    logic [6:0]        quality;
    logic [2:0]        bars;
  } reading_t;

  class quality_scoreboard;
    byte       ring[WIN];
    int        ring_sum;
    int        next_slot;
    bit        primed;
    level_t    levels[4];
    reading_t  expected_readings[$];
    int        errors;
    longint    coef[7];

    function void init();
      primed = 0;
      ring_sum = 0;
      next_slot = 0;
      errors = 0;
      levels[0] = -90;
      levels[1] = -80;
      levels[2] = -70;
      levels[3] = -50;
      // Q24.40 coefficients, constant term first
      coef[0] = 64'sd111371345297556;
      coef[1] = 64'sd702050051029;
      coef[2] = 64'sd89605154045;
      coef[3] = 64'sd4377588081;
      coef[4] = 64'sd87338926;
      coef[5] = 64'sd831429;
      coef[6] = 64'sd3022;
    endfunction

    function logic [6:0] quality_of(int x);
      longint h;
      longint q;
      h = coef[6];
      for (int k = 5; k >= 0; k--) h = coef[k] + longint'(x) * h;
      if (h < 0) return 7'd0;
      q = h >>> 40;
      return (q > 100) ? 7'd100 : 7'(q);
    endfunction

    function void note_request(logic signed [7:0] sample);
      reading_t r;
      int m;
      int n;
      if (!primed) begin
        // first sample fills the whole window
        for (int i = 0; i < WIN; i++) ring[i] = sample;
        ring_sum = int'(sample) * WIN;
        next_slot = 0;
        primed = 1;
      end else begin
        ring_sum = ring_sum - int'(ring[next_slot]) + int'(sample);
        ring[next_slot] = sample;
        next_slot = (next_slot + 1 == WIN) ? 0 : next_slot + 1;
      end
      m = ring_sum / WIN;
      n = 0;
      if (m != 0)
        for (int i = 0; i < 4; i++) if (m > int'(levels[i])) n++;
      r.mean = 8'(m);
      r.quality = quality_of(m);
      r.bars = 3'(n);
      expected_readings.push_back(r);
    endfunction

    function void check_result(logic [7:0] mean, logic [6:0] quality, logic [2:0] bars);
      reading_t r;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result mean=%0d quality=%0d bars=%0d",
                 $time, $signed(mean), quality, bars);
        errors++;
        return;
      end
      r = expected_readings.pop_front();
      if (mean !== r.mean) begin
        $display("%0t: mean_dbm expected %0d actual %0d", $time, r.mean, $signed(mean));
        errors++;
      end
      if (quality !== r.quality) begin
        $display("%0t: quality_percent expected %0d actual %0d", $time, r.quality, quality);
        errors++;
      end
      if (bars !== r.bars) begin
        $display("%0t: bars_lit expected %0d actual %0d", $time, r.bars, bars);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [7:0] rssi_dbm;
  logic out_valid, out_stall;
  logic [7:0] mean_dbm;
  logic [6:0] quality_percent;
  logic [2:0] bars_lit;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  quality_scoreboard sb;
  int burst_left;
  int idle_cycles;
  int stall_mode;
  int stall_count;

  rssi_average_quality_bars dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rssi_dbm(rssi_dbm),
    .out_valid(out_valid), .out_stall(out_stall),
    .mean_dbm(mean_dbm), .quality_percent(quality_percent), .bars_lit(bars_lit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: checks results and stalls on a pattern, one of four, that is picked anew at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(mean_dbm, quality_percent, bars_lit);
    if (rst) begin
      out_stall <= 1'b0;
      stall_count <= 0;
      stall_mode <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count % 64 == 63) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (stall_count % 7 < 3);
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(logic signed [7:0] sample);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    rssi_dbm <= sample;
    do @(posedge clk); while (in_stall);
    sb.note_request(sample);
  endtask

  task automatic write_level(logic [ADDR_W-1:0] addr, level_t value, int idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{24{value[7]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.levels[idx] = value;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_levels(level_t a, level_t b, level_t c, level_t d);
    drain();
    write_level(ADDR_LEVEL_ONE, a, 0);
    write_level(ADDR_LEVEL_TWO, b, 1);
    write_level(ADDR_LEVEL_THREE, c, 2);
    write_level(ADDR_LEVEL_FOUR, d, 3);
  endtask

  function automatic level_t rand_level();
    return level_t'(-$urandom_range(0, 128));
  endfunction

  // mostly random values near a centre, sometimes full-range noise or a long constant run
  task automatic random_phase(int count);
    int done;
    int kind;
    int centre;
    int len;
    int v;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        len = $urandom_range(5, 30);
        if (len > count - done) len = count - done;
        for (int i = 0; i < len; i++) send_request(8'($urandom_range(0, 255)));
      end else if (kind < 4) begin
        case ($urandom_range(0, 3))
          0: v = -128;
          1: v = 127;
          2: v = 0;
          default: v = int'($signed(8'($urandom_range(0, 255))));
        endcase
        len = WIN;
        if (len > count - done) len = count - done;
        for (int i = 0; i < len; i++) send_request(8'(v));
      end else begin
        centre = $urandom_range(0, 1) ? -$urandom_range(0, 128) : $urandom_range(0, 127);
        len = $urandom_range(20, 80);
        if (len > count - done) len = count - done;
        for (int i = 0; i < len; i++) begin
          v = centre + $urandom_range(0, 20) - 10;
          if (v > 127) v = 127;
          if (v < -128) v = -128;
          send_request(8'(v));
        end
      end
      done += len;
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    rst <= 1'b1;
    in_valid <= 1'b0;
    rssi_dbm <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // priming sample at the bottom of the range, then field extremes and bit patterns
    send_request(-8'sd128);
    send_request(8'sd127);
    send_request(8'sd0);
    send_request(-8'sd1);
    send_request(8'sd1);
    send_request(8'h55);
    send_request(8'hAA);
    send_request(-8'sd90);
    send_request(-8'sd50);
    send_request(8'sd64);
    drain();
    write_level(ADDR_LEVEL_ONE, -8'sd128, 0);
    write_level(ADDR_LEVEL_TWO, 8'sd0, 1);
    for (int i = 0; i < 10; i++) send_request(8'sd127);

    random_phase(250);
    set_levels(-8'sd128, -8'sd128, -8'sd128, -8'sd128);
    random_phase(250);
    set_levels(8'sd0, 8'sd0, 8'sd0, 8'sd0);
    random_phase(250);
    set_levels(-8'sd90, -8'sd80, -8'sd70, -8'sd50);
    random_phase(250);
    for (int p = 0; p < 3; p++) begin
      set_levels(rand_level(), rand_level(), rand_level(), rand_level());
      random_phase(300);
    end

    drain();
    if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
